### sv/ngps_pkg.sv
`timescale 1ns / 1ps

package ngps_pkg;

   // fixed field widths
   localparam int COORD_BITS = 16;
   localparam int IDX_BITS   = 5;
   localparam int COUNT_BITS = 6;
   localparam int DIFF_W     = COORD_BITS + 1;
   localparam int SQ_W       = 2 * COORD_BITS;
   localparam int DIST_W     = SQ_W + 1;

   // configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_COUNT = 1'd1;

   // item modes
   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic                         mode;
      logic [IDX_BITS-1:0]          row;
      logic [IDX_BITS-1:0]          col;
      logic signed [COORD_BITS-1:0] point_x;
      logic signed [COORD_BITS-1:0] point_y;
   } req_type;

   typedef struct packed {
      logic [IDX_BITS-1:0] best_col;
      logic [IDX_BITS-1:0] best_row;
      logic [DIST_W-1:0]   best_dist;
      logic                nearest_valid;
   } rsp_type;

   typedef struct packed {
      logic                         query;
      logic                         in_grid;
      logic [IDX_BITS-1:0]          row;
      logic [IDX_BITS-1:0]          col;
      logic signed [COORD_BITS-1:0] point_x;
      logic signed [COORD_BITS-1:0] point_y;
   } cmd_type;

endpackage

### sv/ngps_front.sv
`timescale 1ns / 1ps

module ngps_front #(
   parameter int MAX_ROWS = 32,
   parameter int MAX_COLS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ngps_pkg::req_type req_data,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output ngps_pkg::cmd_type cmd_data
);
   import ngps_pkg::*;

   logic    out_valid_ff, out_valid_in;
   cmd_type cmd_ff, cmd_in;
   logic    accept;

   assign req_ready = !out_valid_ff || cmd_ready;
   assign accept    = req_valid && req_ready;

   // classify: query vs load, and whether a load lands inside the grid
   always_comb begin
      cmd_in.query   = (req_data.mode == MODE_QUERY);
      cmd_in.in_grid = (32'(req_data.row) < MAX_ROWS) && (32'(req_data.col) < MAX_COLS);
      cmd_in.row     = req_data.row;
      cmd_in.col     = req_data.col;
      cmd_in.point_x = req_data.point_x;
      cmd_in.point_y = req_data.point_y;
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (accept) begin
         out_valid_in = 1'b1;
      end else if (cmd_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

   assign cmd_valid = out_valid_ff;
   assign cmd_data  = cmd_ff;

endmodule

### sv/ngps_queue.sv
`timescale 1ns / 1ps

module ngps_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  ngps_pkg::cmd_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output ngps_pkg::cmd_type out_data
);
   import ngps_pkg::*;

   cmd_type            slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               push, pop;

   assign in_ready  = (32'(count_ff) != QUEUE_DEPTH);
   assign out_valid = (count_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_data  = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

### sv/ngps_back.sv
`timescale 1ns / 1ps

module ngps_back #(
   parameter int MAX_ROWS = 32,
   parameter int MAX_COLS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [ngps_pkg::COUNT_BITS-1:0]     row_count,
   input  logic [ngps_pkg::COUNT_BITS-1:0]     col_count,
   input  logic                                cmd_valid,
   output logic                                cmd_ready,
   input  ngps_pkg::cmd_type                   cmd_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output ngps_pkg::rsp_type                   rsp_data
);
   import ngps_pkg::*;

   localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RLW   = $clog2(MAX_ROWS + 1);
   localparam int CLW   = $clog2(MAX_COLS + 1);
   localparam int AW    = RW + CW;
   localparam int DEPTH = 1 << AW;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0] state_ff, state_in;

   // position table, {x, y} per cell
   logic [SQ_W-1:0] table_mem [DEPTH];
   logic [SQ_W-1:0] rd_data_ff;
   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   logic [AW-1:0]   rd_addr;

   logic [RLW-1:0] rows_lim;
   logic [CLW-1:0] cols_lim;
   logic           grid_empty;

   logic [RW-1:0] r_ff, r_in;
   logic [CW-1:0] c_ff, c_in;
   logic          c_last, r_last, iss_last;

   logic signed [COORD_BITS-1:0] qx_ff, qy_ff;

   // scan pipeline: read -> diff -> square -> compare
   logic          v1_ff, v2_ff, v3_ff;
   logic          last1_ff, last2_ff, last3_ff;
   logic [RW-1:0] row1_ff, row2_ff, row3_ff;
   logic [CW-1:0] col1_ff, col2_ff, col3_ff;

   logic signed [COORD_BITS-1:0] mem_x, mem_y;
   logic signed [DIFF_W-1:0]     dx_in, dy_in, dx_ff, dy_ff;
   logic signed [2*DIFF_W-1:0]   prod_x, prod_y;
   logic [SQ_W-1:0]              sqx_ff, sqy_ff;
   logic [DIST_W-1:0]            dist_sum;
   logic                         upd;

   logic              found_ff;
   logic [DIST_W-1:0] best_d_ff;
   logic [RW-1:0]     best_r_ff;
   logic [CW-1:0]     best_c_ff;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic    rsp_load;
   logic    start_query;

   always_comb begin
      rows_lim = (32'(row_count) > MAX_ROWS) ? RLW'(MAX_ROWS) : RLW'(row_count);
      cols_lim = (32'(col_count) > MAX_COLS) ? CLW'(MAX_COLS) : CLW'(col_count);
      grid_empty = (rows_lim == '0) || (cols_lim == '0);
   end

   assign cmd_ready   = (state_ff == ST_IDLE);
   assign start_query = cmd_valid && cmd_ready && cmd_data.query;
   assign wr_en       = cmd_valid && cmd_ready && !cmd_data.query && cmd_data.in_grid;
   assign wr_addr     = {RW'(cmd_data.row), CW'(cmd_data.col)};
   assign rd_addr     = {r_ff, c_ff};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= {cmd_data.point_x, cmd_data.point_y};
      end
      rd_data_ff <= table_mem[rd_addr];
   end

   assign c_last   = (32'(c_ff) == 32'(cols_lim) - 32'd1);
   assign r_last   = (32'(r_ff) == 32'(rows_lim) - 32'd1);
   assign iss_last = c_last && r_last;

   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      r_in     = r_ff;
      c_in     = c_ff;
      unique case (state_ff)
         ST_IDLE: begin
            r_in = '0;
            c_in = '0;
            if (start_query) begin
               state_in = grid_empty ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (c_last) begin
               c_in = '0;
               r_in = r_ff + 1'b1;
            end else begin
               c_in = c_ff + 1'b1;
            end
            if (iss_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (v3_ff && last3_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         r_ff     <= '0;
         c_ff     <= '0;
      end else begin
         state_ff <= state_in;
         r_ff     <= r_in;
         c_ff     <= c_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start_query) begin
         qx_ff <= cmd_data.point_x;
         qy_ff <= cmd_data.point_y;
      end
   end

   // pipeline valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= (state_ff == ST_SCAN);
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   assign mem_x = rd_data_ff[SQ_W-1:COORD_BITS];
   assign mem_y = rd_data_ff[COORD_BITS-1:0];
   assign dx_in = DIFF_W'(mem_x) - DIFF_W'(qx_ff);
   assign dy_in = DIFF_W'(mem_y) - DIFF_W'(qy_ff);
   assign prod_x = dx_ff * dx_ff;
   assign prod_y = dy_ff * dy_ff;

   always_ff @(posedge clock) begin
      last1_ff <= iss_last;
      row1_ff  <= r_ff;
      col1_ff  <= c_ff;
      last2_ff <= last1_ff;
      row2_ff  <= row1_ff;
      col2_ff  <= col1_ff;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      last3_ff <= last2_ff;
      row3_ff  <= row2_ff;
      col3_ff  <= col2_ff;
      sqx_ff   <= prod_x[SQ_W-1:0];
      sqy_ff   <= prod_y[SQ_W-1:0];
   end

   // strict compare keeps the first cell in row-major order on ties
   assign dist_sum = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign upd      = v3_ff && (!found_ff || dist_sum < best_d_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (start_query) begin
         found_ff <= 1'b0;
      end else if (upd) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (upd) begin
         best_d_ff <= dist_sum;
         best_r_ff <= row3_ff;
         best_c_ff <= col3_ff;
      end
   end

   always_comb begin
      rsp_in.best_col      = found_ff ? IDX_BITS'(best_c_ff) : '0;
      rsp_in.best_row      = found_ff ? IDX_BITS'(best_r_ff) : '0;
      rsp_in.best_dist     = found_ff ? best_d_ff : '0;
      rsp_in.nearest_valid = found_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### sv/nearest_grid_point_search_top.sv
`timescale 1ns / 1ps
// Load beat: registered in front and queue, then written into the position table; one load
// per cycle sustained while the back end is idle. Query beat: holds the back end until its
// response is registered; one-cell-per-cycle scan (one read port), read/diff/square/compare
// pipeline. Empty grid: no scan. Front register and a 2-entry queue take new beats in a scan.
// Reset (synchronous, active high) clears control state and both count registers to zero;
// the position table is undefined until loaded and gets no clearing pass.

module nearest_grid_point_search_top #(
   parameter int MAX_ROWS = 32,
   parameter int MAX_COLS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  ngps_pkg::req_type                   req_data,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output ngps_pkg::rsp_type                   rsp_data,
   // configuration writes
   input  logic                                csr_we,
   input  logic [ngps_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ngps_pkg::COUNT_BITS-1:0]     csr_wdata
);
   import ngps_pkg::*;

   // grid size registers; saturated to MAX_* in the back end
   logic [COUNT_BITS-1:0] row_count_ff, row_count_in;
   logic [COUNT_BITS-1:0] col_count_ff, col_count_in;

   always_comb begin
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ROW_COUNT: row_count_in = csr_wdata;
            CSR_COL_COUNT: col_count_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= '0;
         col_count_ff <= '0;
      end else begin
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
      end
   end

   // front -> queue -> back
   logic    f_valid, f_ready;
   cmd_type f_data;
   logic    q_valid, q_ready;
   cmd_type q_data;

   // front: registers the beat, flags query vs load and grid bounds
   ngps_front #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_valid (f_valid),
      .cmd_ready (f_ready),
      .cmd_data  (f_data)
   );

   // short command queue so the front keeps taking beats during a scan
   ngps_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (f_data),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_data)
   );

   // back: owns the position table, runs loads and the nearest-cell scan
   ngps_back #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .row_count (row_count_ff),
      .col_count (col_count_ff),
      .cmd_valid (q_valid),
      .cmd_ready (q_ready),
      .cmd_data  (q_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
